### rtl/core/sfpc_pkg.sv
`default_nettype none
package sfpc_pkg;

	localparam int IMAGE_BYTES        = 4736;
	localparam int NUM_DISPLAYS       = 3;
	localparam int ACTION_BYTES       = 255;
	localparam int FRAMES_PER_REFRESH = 3;
	localparam int QUEUE_DEPTH        = 2;

	localparam int IN_W  = 8;
	localparam int OUT_W = 40;

	localparam logic [7:0] HDR_FIRST  = 8'hAA;
	localparam logic [7:0] HDR_SECOND = 8'h55;

	localparam logic [3:0] NIB_SELECT = 4'h0;
	localparam logic [3:0] NIB_IMAGE  = 4'h1;
	localparam logic [3:0] NIB_ACTION = 4'h2;

	typedef enum logic [2:0] {
		PH_HUNT1 = 3'd0,
		PH_HUNT2 = 3'd1,
		PH_TYPE  = 3'd2,
		PH_LEN   = 3'd3,
		PH_DATA  = 3'd4,
		PH_SUM   = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		OP_IDLE,
		OP_SELECT,
		OP_IMAGE,
		OP_ACTION,
		OP_DISCARD,
		OP_END
	} op_t;

	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_IMAGE  = 2'd1,
		KIND_ACTION = 2'd2,
		KIND_END    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		REPLY_NONE = 2'd0,
		REPLY_ACK  = 2'd1,
		REPLY_NAK  = 2'd2
	} reply_t;

	typedef struct packed {
		op_t         op;
		logic [7:0]  data;
		logic [12:0] offset;
		logic        in_range;
		logic        counted;
	} cmd_t;

	typedef struct packed {
		logic        full;
		logic        empty;
	} q_status_t;

	// packed msb first, so write_kind lands in the lowest bits
	typedef struct packed {
		logic [1:0]  pad;
		logic        write_dropped;
		logic [1:0]  refresh_display;
		logic [7:0]  commit_length;
		reply_t      reply_code;
		logic [7:0]  data_byte;
		logic [12:0] byte_offset;
		logic [1:0]  display_index;
		kind_t       write_kind;
	} result_t;

endpackage
`default_nettype wire

### rtl/core/sfpc_front.sv
`default_nettype none
module sfpc_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          fire,
	input  wire logic [7:0]    rx_byte,
	output sfpc_pkg::cmd_t     cmd
);

	sfpc_pkg::phase_t phase_q, phase_nxt;
	logic [7:0]  type_q;
	logic [1:0]  len_cnt_q;
	logic [31:0] len_q;
	logic [31:0] rcv_q;
	logic [31:0] len_new;
	logic [31:0] rcv_inc;
	logic [3:0]  nib;

	assign nib     = type_q[3:0];
	assign len_new = len_q | ({24'b0, rx_byte} << {len_cnt_q, 3'b000});
	assign rcv_inc = rcv_q + 32'd1;

	always_comb begin
		phase_nxt = sfpc_pkg::PH_HUNT1;
		case (phase_q)
			sfpc_pkg::PH_HUNT2: begin
				phase_nxt = (rx_byte == sfpc_pkg::HDR_SECOND) ? sfpc_pkg::PH_TYPE
					: sfpc_pkg::PH_HUNT1;
			end
			sfpc_pkg::PH_TYPE: phase_nxt = sfpc_pkg::PH_LEN;
			sfpc_pkg::PH_LEN: begin
				phase_nxt = sfpc_pkg::PH_LEN;
				if (len_cnt_q == 2'd3) begin
					phase_nxt = (nib != sfpc_pkg::NIB_SELECT && len_new == 32'd0)
						? sfpc_pkg::PH_SUM : sfpc_pkg::PH_DATA;
				end
			end
			sfpc_pkg::PH_DATA: begin
				phase_nxt = sfpc_pkg::PH_DATA;
				if (nib == sfpc_pkg::NIB_SELECT || rcv_inc >= len_q)
					phase_nxt = sfpc_pkg::PH_SUM;
			end
			sfpc_pkg::PH_SUM: phase_nxt = sfpc_pkg::PH_HUNT1;
			default: begin
				phase_nxt = (rx_byte == sfpc_pkg::HDR_FIRST) ? sfpc_pkg::PH_HUNT2
					: sfpc_pkg::PH_HUNT1;
			end
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.op       = sfpc_pkg::OP_IDLE;
		cmd.data     = rx_byte;
		cmd.offset   = rcv_q[12:0];
		cmd.in_range = (rcv_q < 32'(sfpc_pkg::IMAGE_BYTES));
		cmd.counted  = (type_q[7:4] != 4'h0);
		case (phase_q)
			sfpc_pkg::PH_DATA: begin
				case (nib)
					sfpc_pkg::NIB_SELECT: cmd.op = sfpc_pkg::OP_SELECT;
					sfpc_pkg::NIB_IMAGE:  cmd.op = sfpc_pkg::OP_IMAGE;
					sfpc_pkg::NIB_ACTION: cmd.op = sfpc_pkg::OP_ACTION;
					default:              cmd.op = sfpc_pkg::OP_DISCARD;
				endcase
			end
			sfpc_pkg::PH_SUM: cmd.op = sfpc_pkg::OP_END;
			default:          cmd.op = sfpc_pkg::OP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= sfpc_pkg::PH_HUNT1;
			type_q    <= '0;
			len_cnt_q <= '0;
			len_q     <= '0;
			rcv_q     <= '0;
		end else if (fire) begin
			phase_q <= phase_nxt;
			case (phase_q)
				sfpc_pkg::PH_TYPE: begin
					type_q    <= rx_byte;
					len_cnt_q <= '0;
					len_q     <= '0;
				end
				sfpc_pkg::PH_LEN: begin
					len_q     <= len_new;
					len_cnt_q <= len_cnt_q + 2'd1;
				end
				sfpc_pkg::PH_DATA: begin
					// a display select byte does not advance the offset
					if (nib != sfpc_pkg::NIB_SELECT)
						rcv_q <= rcv_inc;
				end
				sfpc_pkg::PH_SUM: begin
					rcv_q     <= '0;
					len_q     <= '0;
					len_cnt_q <= '0;
				end
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

### rtl/core/sfpc_queue.sv
`default_nettype none
module sfpc_queue #(
	parameter int DEPTH = sfpc_pkg::QUEUE_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire sfpc_pkg::cmd_t    push_cmd,
	input  wire logic              pop,
	output sfpc_pkg::cmd_t         head_cmd,
	output sfpc_pkg::q_status_t    status
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	sfpc_pkg::cmd_t slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign head_cmd     = slot_q[rd_ptr_q];
	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign status.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wrap_inc(wr_ptr_q);
			if (pop)
				rd_ptr_q <= wrap_inc(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

endmodule
`default_nettype wire

### rtl/core/sfpc_back.sv
`default_nettype none
module sfpc_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cmd_valid,
	input  wire sfpc_pkg::cmd_t        cmd,
	output logic                       pop,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [sfpc_pkg::OUT_W-1:0] m_tdata
);

	logic [7:0] sum_q, sum_nxt;
	logic [7:0] sel_q, sel_nxt;
	logic [7:0] staged_q, staged_nxt;
	logic [3:0] frames_q, frames_nxt, frames_inc;
	logic       valid_q;
	logic       disp_ok;
	logic [1:0] disp_out;
	sfpc_pkg::result_t res, res_q;

	assign pop      = cmd_valid && (!valid_q || m_tready);
	assign disp_ok  = (sel_q >= 8'd1) && (sel_q <= 8'(sfpc_pkg::NUM_DISPLAYS));
	assign disp_out = disp_ok ? sel_q[1:0] : 2'd0;
	assign frames_inc = cmd.counted ? frames_q + 4'd1 : frames_q;

	always_comb begin
		res               = '0;
		res.write_kind    = sfpc_pkg::KIND_NONE;
		res.reply_code    = sfpc_pkg::REPLY_NONE;
		res.display_index = disp_out;
		sum_nxt           = sum_q + cmd.data;
		sel_nxt           = sel_q;
		staged_nxt        = staged_q;
		frames_nxt        = frames_q;
		case (cmd.op)
			sfpc_pkg::OP_SELECT: begin
				// the new selection is reported on the same beat
				sel_nxt = cmd.data;
				res.display_index = ((cmd.data >= 8'd1) &&
					(cmd.data <= 8'(sfpc_pkg::NUM_DISPLAYS))) ? cmd.data[1:0] : 2'd0;
			end
			sfpc_pkg::OP_IMAGE: begin
				if (disp_ok && cmd.in_range) begin
					res.write_kind  = sfpc_pkg::KIND_IMAGE;
					res.byte_offset = cmd.offset;
					res.data_byte   = cmd.data;
				end else begin
					res.write_dropped = 1'b1;
				end
			end
			sfpc_pkg::OP_ACTION: begin
				if (staged_q < 8'(sfpc_pkg::ACTION_BYTES)) begin
					res.write_kind  = sfpc_pkg::KIND_ACTION;
					res.byte_offset = cmd.offset;
					res.data_byte   = cmd.data;
					staged_nxt      = staged_q + 8'd1;
				end else begin
					res.write_dropped = 1'b1;
				end
			end
			sfpc_pkg::OP_DISCARD: ;
			sfpc_pkg::OP_END: begin
				res.write_kind    = sfpc_pkg::KIND_END;
				res.reply_code    = (cmd.data == sum_q) ? sfpc_pkg::REPLY_ACK
					: sfpc_pkg::REPLY_NAK;
				res.commit_length = staged_q;
				res.write_dropped = !disp_ok;
				sum_nxt           = '0;
				staged_nxt        = '0;
				frames_nxt        = frames_inc;
				if (frames_inc >= 4'(sfpc_pkg::FRAMES_PER_REFRESH)) begin
					res.refresh_display = disp_out;
					frames_nxt          = '0;
					sel_nxt             = '0;
				end
			end
			default: sum_nxt = sum_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			sel_q    <= '0;
			staged_q <= '0;
			frames_q <= '0;
			valid_q  <= 1'b0;
		end else begin
			if (pop) begin
				sum_q    <= sum_nxt;
				sel_q    <= sel_nxt;
				staged_q <= staged_nxt;
				frames_q <= frames_nxt;
			end
			if (pop)
				valid_q <= 1'b1;
			else if (m_tready)
				valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			res_q <= res;
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = res_q;

endmodule
`default_nettype wire

### rtl/core/serial_frame_parser_checksum.sv
// serial frame parser with additive checksum
// s_* channel: one received byte per beat (s_tdata = rx_byte).
// m_* channel: exactly one result beat for every input beat, in order.
// a frame is AA 55, a type byte, a 32-bit little-endian length, payload and a
// sum byte; result beats carry image writes, action stages and the frame end
// with its ack or nak, commit length and refresh request.
// the result beat of a byte is written into the queue, then popped into the
// output register, from which the receiver takes it.
// throughput: one byte per cycle while the queue is not full; the parser front
// end writes a command per byte into a QUEUE_DEPTH-entry queue, the back end
// drains one per cycle into the output register while the receiver takes beats.
// when m_tready is low the output register holds its beat and the queue
// fills; s_tready falls only once the queue is full, and rises again as soon
// as the receiver takes a beat.
// reset returns the parser to the header hunt and clears the checksum, the
// display selection, the staged action count and the frame counter; no result
// beat is pending after reset.
`default_nettype none
module serial_frame_parser_checksum #(
	parameter int QUEUE_DEPTH = sfpc_pkg::QUEUE_DEPTH
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	input  wire logic [sfpc_pkg::IN_W-1:0]  s_tdata,   // [7:0] rx_byte
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	// [1:0] write_kind, [3:2] display_index, [16:4] byte_offset,
	// [24:17] data_byte, [26:25] reply_code, [34:27] commit_length,
	// [36:35] refresh_display, [37] write_dropped, [39:38] zero
	output logic [sfpc_pkg::OUT_W-1:0]      m_tdata
);

	sfpc_pkg::cmd_t      front_cmd, head_cmd;
	sfpc_pkg::q_status_t q_stat;
	logic                fire, pop;

	assign s_tready = !q_stat.full;
	assign fire     = s_tvalid && s_tready;

	sfpc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.rx_byte (s_tdata),
		.cmd     (front_cmd)
	);

	sfpc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (fire),
		.push_cmd (front_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.status   (q_stat)
	);

	sfpc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (!q_stat.empty),
		.cmd       (head_cmd),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

`ifndef ASSERT_OFF
	// only a frame end carries a reply, a commit length or a refresh
	a_end_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] != sfpc_pkg::KIND_END) |-> (m_tdata[36:25] == '0))
		else $error("reply or commit outside frame end");

	a_end_reply: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] == sfpc_pkg::KIND_END) |->
		(m_tdata[26:25] == sfpc_pkg::REPLY_ACK || m_tdata[26:25] == sfpc_pkg::REPLY_NAK))
		else $error("frame end without ack or nak");

	a_write_not_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] == sfpc_pkg::KIND_IMAGE ||
		m_tdata[1:0] == sfpc_pkg::KIND_ACTION) |-> !m_tdata[37])
		else $error("write both issued and dropped");

	// no result beat appears without a queued command behind it
	a_no_invented_beat: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.empty && !m_tvalid |=> !m_tvalid)
		else $error("result beat from an empty queue");
`endif

endmodule
`default_nettype wire

### tb/sv/tb_serial_frame_parser_checksum.sv
module tb_serial_frame_parser_checksum;
	import sfpc_pkg::*;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata = '0;   // [7:0] rx_byte
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	// [1:0] write_kind, [3:2] display_index, [16:4] byte_offset,
	// [24:17] data_byte, [26:25] reply_code, [34:27] commit_length,
	// [36:35] refresh_display, [37] write_dropped, [39:38] zero
	logic [OUT_W-1:0]    m_tdata;

	serial_frame_parser_checksum uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// parser mirror, state as after reset
	phase_t      rx_phase       = PH_HUNT1;
	logic [7:0]  frm_type       = '0;
	logic [1:0]  len_count      = '0;
	logic [31:0] frm_len        = '0;
	logic [31:0] payload_count  = '0;
	logic [7:0]  payload_sum    = '0;
	logic [7:0]  display_sel    = '0;
	logic [3:0]  counted_frames = '0;
	logic [7:0]  staged_actions = '0;

	result_t     expected_results[$];
	logic [7:0]  frame_body[$];
	int          mismatch_count = 0;
	int          bytes_sent     = 0;
	int          burst_left     = 0;
	bit          gaps_enabled   = 1'b1;

	function automatic bit display_valid();
		return display_sel >= 1 && display_sel <= NUM_DISPLAYS;
	endfunction

	function automatic logic [1:0] display_code();
		return display_valid() ? display_sel[1:0] : 2'd0;
	endfunction

	function automatic result_t predict_beat(input logic [7:0] b);
		result_t    r;
		logic [3:0] nib;
		r = '0;
		nib = frm_type[3:0];
		case (rx_phase)
		PH_HUNT2: rx_phase = (b == HDR_SECOND) ? PH_TYPE : PH_HUNT1;
		PH_TYPE: begin
			frm_type = b;
			len_count = '0;
			frm_len = '0;
			rx_phase = PH_LEN;
		end
		PH_LEN: begin
			frm_len = frm_len | ({24'd0, b} << (8 * len_count));
			len_count = len_count + 2'd1;
			if (len_count == 2'd0)
				rx_phase = (nib != NIB_SELECT && frm_len == 0) ? PH_SUM : PH_DATA;
		end
		PH_DATA: begin
			payload_sum = payload_sum + b;
			if (nib == NIB_SELECT) begin
				display_sel = b;
				rx_phase = PH_SUM;
			end else begin
				if (nib == NIB_IMAGE) begin
					if (display_valid() && payload_count < IMAGE_BYTES) begin
						r.write_kind = KIND_IMAGE;
						r.byte_offset = payload_count[12:0];
						r.data_byte = b;
					end else begin
						r.write_dropped = 1'b1;
					end
				end else if (nib == NIB_ACTION) begin
					if (staged_actions < ACTION_BYTES) begin
						r.write_kind = KIND_ACTION;
						r.byte_offset = payload_count[12:0];
						r.data_byte = b;
						staged_actions = staged_actions + 8'd1;
					end else begin
						r.write_dropped = 1'b1;
					end
				end
				payload_count = payload_count + 32'd1;
				if (payload_count >= frm_len)
					rx_phase = PH_SUM;
			end
		end
		PH_SUM: begin
			r.write_kind = KIND_END;
			r.reply_code = (b == payload_sum) ? REPLY_ACK : REPLY_NAK;
			r.commit_length = staged_actions;
			r.write_dropped = !display_valid();
			r.display_index = display_code();
			if (frm_type[7:4] != 4'd0)
				counted_frames = counted_frames + 4'd1;
			if (counted_frames >= FRAMES_PER_REFRESH) begin
				r.refresh_display = display_code();
				counted_frames = '0;
				display_sel = '0;
			end
			rx_phase = PH_HUNT1;
			payload_count = '0;
			payload_sum = '0;
			frm_len = '0;
			len_count = '0;
			staged_actions = '0;
		end
		default: rx_phase = (b == HDR_FIRST) ? PH_HUNT2 : PH_HUNT1;
		endcase
		// the frame end beat reports the selection from before the clear
		if (r.write_kind != KIND_END)
			r.display_index = display_code();
		return r;
	endfunction

	// random byte that never opens a long length field
	function automatic logic [7:0] safe_random_byte();
		if (rx_phase == PH_LEN)
			return (len_count == 2'd0) ? 8'($urandom_range(0, 6)) : 8'd0;
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(0, 1) ? HDR_FIRST : HDR_SECOND;
		return 8'($urandom_range(0, 255));
	endfunction

	// sender: called at a rising edge, returns at the edge that takes the beat
	task automatic send_byte(input logic [7:0] b);
		if (gaps_enabled && burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
		if (burst_left != 0)
			burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		expected_results.insert(expected_results.size(), predict_beat(b));
		bytes_sent++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic fill_body(input int n);
		frame_body.delete();
		repeat (n) frame_body.insert(frame_body.size(), 8'($urandom_range(0, 255)));
	endtask

	task automatic send_frame(input logic [7:0] ftype, input logic [31:0] flen,
			input bit good_sum);
		logic [7:0] sum;
		int         n;
		sum = '0;
		n = (ftype[3:0] == NIB_SELECT) ? 1 : int'(flen);
		send_byte(HDR_FIRST);
		send_byte(HDR_SECOND);
		send_byte(ftype);
		for (int i = 0; i < 4; i++)
			send_byte(flen[8*i +: 8]);
		for (int i = 0; i < n; i++) begin
			send_byte(frame_body[i]);
			sum = sum + frame_body[i];
		end
		send_byte(good_sum ? sum : sum + 8'($urandom_range(1, 255)));
	endtask

	task automatic send_select(input logic [7:0] ftype, input logic [31:0] flen,
			input logic [7:0] disp);
		fill_body(1);
		frame_body[0] = disp;
		send_frame(ftype, flen, 1'b1);
	endtask

	// walk the parser back to the header hunt
	task automatic resync();
		while (rx_phase != PH_HUNT1)
			send_byte(safe_random_byte());
	endtask

	task automatic test_header_hunt();
		send_byte(8'h00);
		send_byte(HDR_FIRST);
		send_byte(HDR_FIRST);   // taken as a bad second byte, not a new start
		send_byte(HDR_SECOND);
		send_byte(8'hFF);
		send_byte(HDR_SECOND);
		send_byte(HDR_FIRST);
		send_byte(8'h00);
		send_select(8'h00, 32'h0, 8'd2);
		send_select(8'h00, 32'hFFFF_FFFF, 8'd3);
	endtask

	task automatic test_image_writes();
		send_select(8'h00, 32'h1, 8'd1);
		frame_body = '{8'h00, 8'hFF, 8'h5A, 8'hA5};
		send_frame(8'h01, 32'd4, 1'b1);
		send_frame(8'h01, 32'd4, 1'b0);
	endtask

	task automatic test_action_stage();
		fill_body(3);
		send_frame(8'h02, 32'd3, 1'b1);
		fill_body(0);
		send_frame(8'h02, 32'd0, 1'b1);
	endtask

	task automatic test_unknown_type();
		fill_body(3);
		send_frame(8'h07, 32'd3, 1'b1);
		fill_body(0);
		send_frame(8'h0F, 32'd0, 1'b0);
	endtask

	task automatic test_bad_display();
		send_select(8'h00, 32'h1, 8'd0);
		fill_body(2);
		send_frame(8'h01, 32'd2, 1'b1);
		send_select(8'h00, 32'h1, 8'hFF);
		fill_body(1);
		send_frame(8'h02, 32'd1, 1'b1);
		wait_drained();
	endtask

	task automatic test_refresh();
		send_select(8'h10, 32'h0, 8'd3);
		fill_body(2);
		send_frame(8'hF1, 32'd2, 1'b1);
		send_select(8'h80, 32'h0, 8'd2);
		// another round with the selection out of range
		send_select(8'h20, 32'h0, 8'd7);
		fill_body(0);
		send_frame(8'h33, 32'd0, 1'b1);
		send_frame(8'hF3, 32'd0, 1'b1);
	endtask

	task automatic test_image_overflow();
		gaps_enabled = 1'b0;
		send_select(8'h00, 32'h0, 8'd1);
		fill_body(IMAGE_BYTES + 4);
		send_frame(8'h01, 32'(IMAGE_BYTES + 4), 1'b1);
		gaps_enabled = 1'b1;
	endtask

	task automatic test_action_overflow();
		fill_body(ACTION_BYTES + 3);
		send_frame(8'h02, 32'(ACTION_BYTES + 3), 1'b0);
		wait_drained();
	endtask

	task automatic test_random_frames();
		int          sel;
		int          start;
		logic [7:0]  ftype;
		logic [31:0] flen;
		start = bytes_sent;
		while (bytes_sent - start < 950) begin
			sel = $urandom_range(0, 99);
			if (sel < 3) begin
				gaps_enabled = !gaps_enabled;
			end else if (sel < 5) begin
				wait_drained();
			end else if (sel < 15) begin
				repeat ($urandom_range(1, 6)) send_byte(safe_random_byte());
				resync();
			end else if (sel < 22) begin
				send_byte(HDR_FIRST);
				send_byte(8'($urandom_range(0, 255)));
				resync();
			end else begin
				ftype[7:4] = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(1, 15));
				case ($urandom_range(0, 9))
				0, 1, 2: ftype[3:0] = NIB_SELECT;
				3, 4, 5: ftype[3:0] = NIB_IMAGE;
				6, 7, 8: ftype[3:0] = NIB_ACTION;
				default: ftype[3:0] = 4'($urandom_range(3, 15));
				endcase
				if (ftype[3:0] == NIB_SELECT) begin
					flen = $urandom();
					fill_body(1);
					if ($urandom_range(0, 3) != 0)
						frame_body[0] = 8'($urandom_range(0, 4));
				end else begin
					flen = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom_range(1, 12));
					fill_body(int'(flen));
				end
				send_frame(ftype, flen, $urandom_range(0, 4) != 0);
			end
		end
		gaps_enabled = 1'b1;
	endtask

	// receiver: runs of always ready, coin flips, long stalls and sparse ready
	int rdy_mode   = 0;
	int rdy_left   = 0;
	int stall_left = 0;

	always @(posedge clk) begin
		if (rdy_left == 0) begin
			rdy_mode = $urandom_range(0, 3);
			rdy_left = $urandom_range(20, 300);
		end
		rdy_left--;
		if (stall_left != 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			case (rdy_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			2: begin
				if ($urandom_range(0, 19) == 0)
					stall_left = $urandom_range(1, 16);
				m_tready <= (stall_left == 0);
			end
			default: m_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			mismatch_count++;
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
		end
	endtask

	// sampled between edges, so the beat seen here is taken at the next edge
	always @(negedge clk) begin : result_check
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = result_t'(m_tdata);
			if (expected_results.size() == 0) begin
				mismatch_count++;
				$display("%0t: beat with nothing expected, expected none actual %h",
					$time, m_tdata);
			end else begin
				want = expected_results.pop_front();
				check_field("write_kind", want.write_kind, got.write_kind);
				check_field("display_index", want.display_index, got.display_index);
				check_field("byte_offset", want.byte_offset, got.byte_offset);
				check_field("data_byte", want.data_byte, got.data_byte);
				check_field("reply_code", want.reply_code, got.reply_code);
				check_field("commit_length", want.commit_length, got.commit_length);
				check_field("refresh_display", want.refresh_display, got.refresh_display);
				check_field("write_dropped", want.write_dropped, got.write_dropped);
				check_field("pad", want.pad, got.pad);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_header_hunt();
		test_image_writes();
		test_action_stage();
		test_unknown_type();
		test_bad_display();
		test_refresh();
		test_image_overflow();
		test_action_overflow();
		test_random_frames();
		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

### files.f
rtl/core/sfpc_pkg.sv
rtl/core/sfpc_front.sv
rtl/core/sfpc_queue.sv
rtl/core/sfpc_back.sv
rtl/core/serial_frame_parser_checksum.sv
tb/sv/tb_serial_frame_parser_checksum.sv
